/* sv/tblc_pkg.sv */
// ============================================================================
// tblc_pkg: shared types and constants for the two-button lamp controller
// Register indexes, configuration and item structures and the colour table.
// ============================================================================
package tblc_pkg;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_INITIAL_EFFECT = 3'd0,
        REG_INITIAL_LEVEL  = 3'd1,
        REG_HOLD_MS        = 3'd2,
        REG_HOLD_WINDOW_MS = 3'd3,
        REG_LEVEL_STEP     = 3'd4,
        REG_HUE_STEP       = 3'd5,
        REG_BLINK_PERIOD   = 3'd6,
        REG_SAVE_PERIOD    = 3'd7
    } reg_index_t;

    localparam int unsigned CFG_DATA_W = 16;

    // Effect index that selects the rainbow hue; lower indexes use the table.
    localparam logic [7:0] EFFECT_RAINBOW = 8'd13;

    localparam logic [10:0] PRESS_MAX = 11'd2047;

    // Configuration values used by the item logic.
    typedef struct packed {
        logic [10:0] hold_ms;
        logic [8:0]  hold_window_ms;
        logic [7:0]  level_step;
        logic [15:0] hue_step;
        logic [7:0]  blink_period;
        logic [11:0] save_period;
    } cfg_t;

    // Preset loads that overwrite the working state.
    typedef struct packed {
        logic       load_effect;
        logic       load_level;
        logic [7:0] value;
    } preset_t;

    // One input item.
    typedef struct packed {
        logic ms_tick;
        logic period_event;
        logic button_a_level;
        logic button_b_level;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        hsv_mode;
        logic [15:0] hue_out;
        logic [7:0]  shown_brightness;
        logic [7:0]  level_out;
        logic [7:0]  effect_out;
        logic        adjust_mode;
        logic        save_strobe;
    } result_t;

    // Fixed colours, packed as red, green, blue from the top byte down.
    function automatic logic [23:0] colour_lookup(input logic [3:0] idx);
        logic [23:0] rgb;
        begin
            rgb = 24'h000000;
            case (idx)
                4'd0:    rgb = {8'd255, 8'd255, 8'd255};
                4'd1:    rgb = {8'd255, 8'd244, 8'd150};
                4'd2:    rgb = {8'd255, 8'd0,   8'd0};
                4'd3:    rgb = {8'd255, 8'd127, 8'd0};
                4'd4:    rgb = {8'd255, 8'd255, 8'd0};
                4'd5:    rgb = {8'd128, 8'd255, 8'd0};
                4'd6:    rgb = {8'd0,   8'd255, 8'd0};
                4'd7:    rgb = {8'd0,   8'd255, 8'd128};
                4'd8:    rgb = {8'd0,   8'd255, 8'd255};
                4'd9:    rgb = {8'd0,   8'd128, 8'd255};
                4'd10:   rgb = {8'd0,   8'd0,   8'd255};
                4'd11:   rgb = {8'd128, 8'd0,   8'd255};
                4'd12:   rgb = {8'd255, 8'd0,   8'd255};
                default: rgb = 24'h000000;
            endcase
            return rgb;
        end
    endfunction

endpackage

/* sv/tblc_cfg.sv */
// ============================================================================
// tblc_cfg: configuration register file
// Holds the run-time settings and raises preset loads for the working state.
// ============================================================================
module tblc_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_index,
    input  logic [tblc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output tblc_pkg::cfg_t                     cfg,
    output tblc_pkg::preset_t                  preset
);

    tblc_pkg::cfg_t cfg_reg;
    tblc_pkg::cfg_t cfg_next;

    // Register decode.
    always_comb
    begin
        cfg_next           = cfg_reg;
        preset.load_effect = 1'b0;
        preset.load_level  = 1'b0;
        preset.value       = cfg_wdata[7:0];
        if (cfg_we)
        begin
            unique case (tblc_pkg::reg_index_t'(cfg_index))
                tblc_pkg::REG_INITIAL_EFFECT: preset.load_effect = 1'b1;
                tblc_pkg::REG_INITIAL_LEVEL:  preset.load_level  = 1'b1;
                tblc_pkg::REG_HOLD_MS:        cfg_next.hold_ms = cfg_wdata[10:0];
                tblc_pkg::REG_HOLD_WINDOW_MS: cfg_next.hold_window_ms = cfg_wdata[8:0];
                tblc_pkg::REG_LEVEL_STEP:     cfg_next.level_step = cfg_wdata[7:0];
                tblc_pkg::REG_HUE_STEP:       cfg_next.hue_step = cfg_wdata[15:0];
                tblc_pkg::REG_BLINK_PERIOD:   cfg_next.blink_period = cfg_wdata[7:0];
                tblc_pkg::REG_SAVE_PERIOD:    cfg_next.save_period = cfg_wdata[11:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // Settings with their reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ms        <= 11'd1000;
            cfg_reg.hold_window_ms <= 9'd20;
            cfg_reg.level_step     <= 8'd32;
            cfg_reg.hue_step       <= 16'd128;
            cfg_reg.blink_period   <= 8'd30;
            cfg_reg.save_period    <= 12'd480;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/tblc_step.sv */
// ============================================================================
// tblc_step: lamp state and per-item update
// Holds the lamp state and computes the next state and result of one item.
// ============================================================================
module tblc_step
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  tblc_pkg::item_t      item,
    input  tblc_pkg::cfg_t       cfg,
    input  tblc_pkg::preset_t    preset,
    output tblc_pkg::result_t    result
);

    logic        last_a_reg,    last_a_next;
    logic        last_b_reg,    last_b_next;
    logic [10:0] press_reg,     press_next;
    logic        adjust_reg,    adjust_next;
    logic [7:0]  effect_reg,    effect_next;
    logic [7:0]  level_reg,     level_next;
    logic [7:0]  applied_reg,   applied_next;
    logic        phase_reg,     phase_next;
    logic [7:0]  blink_cnt_reg, blink_cnt_next;
    logic [12:0] save_cnt_reg,  save_cnt_next;
    logic [15:0] hue_reg,       hue_next;
    logic [23:0] rgb_reg,       rgb_next;
    logic        is_hsv_reg,    is_hsv_next;
    logic [15:0] snap_reg,      snap_next;
    logic        strobe;

    logic [11:0] window_end;
    logic        in_window_a;
    logic        in_window_b;
    logic [8:0]  step_plus_one;

    assign window_end    = {1'b0, cfg.hold_ms} + {3'b000, cfg.hold_window_ms};
    assign step_plus_one = {1'b0, cfg.level_step} + 9'd1;

    // Item update: millisecond tick, periodic event, button A, button B, colour.
    always_comb
    begin
        last_a_next    = last_a_reg;
        last_b_next    = last_b_reg;
        press_next     = press_reg;
        adjust_next    = adjust_reg;
        effect_next    = effect_reg;
        level_next     = level_reg;
        applied_next   = applied_reg;
        phase_next     = phase_reg;
        blink_cnt_next = blink_cnt_reg;
        save_cnt_next  = save_cnt_reg;
        hue_next       = hue_reg;
        rgb_next       = rgb_reg;
        is_hsv_next    = is_hsv_reg;
        snap_next      = snap_reg;
        strobe         = 1'b0;
        in_window_a    = 1'b0;
        in_window_b    = 1'b0;

        // Press timer, saturating.
        if (item.ms_tick && (press_next != tblc_pkg::PRESS_MAX))
        begin
            press_next = press_next + 11'd1;
        end

        // Periodic event: hue, blink divider and save divider.
        if (item.period_event)
        begin
            hue_next = hue_reg + cfg.hue_step;
            if (blink_cnt_reg > cfg.blink_period)
            begin
                if (adjust_reg && !phase_reg)
                begin
                    applied_next = 8'd1;
                    phase_next   = 1'b1;
                end
                else
                begin
                    applied_next = level_reg;
                    phase_next   = 1'b0;
                end
                blink_cnt_next = 8'd0;
            end
            else
            begin
                blink_cnt_next = blink_cnt_reg + 8'd1;
            end
            if (save_cnt_reg > {1'b0, cfg.save_period})
            begin
                strobe        = 1'b1;
                save_cnt_next = 13'd0;
            end
            else
            begin
                save_cnt_next = save_cnt_reg + 13'd1;
            end
        end

        // Button A: press clears the timer, hold enters adjust, release steps up.
        if (!item.button_a_level && last_a_reg)
        begin
            press_next = 11'd0;
        end
        else if (!item.button_a_level && !last_a_reg)
        begin
            in_window_a = (press_next > cfg.hold_ms) && ({1'b0, press_next} < window_end);
            if (in_window_a)
            begin
                adjust_next = 1'b1;
            end
        end
        else if (item.button_a_level && !last_a_reg)
        begin
            if (adjust_next)
            begin
                if (level_next > (8'd255 - cfg.level_step))
                begin
                    level_next = 8'd255;
                end
                else
                begin
                    level_next = level_next + cfg.level_step;
                end
                applied_next = level_next;
            end
            else
            begin
                effect_next = effect_next + 8'd1;
            end
        end
        last_a_next = item.button_a_level;

        // Button B: press clears the timer, hold leaves adjust, release steps down.
        if (!item.button_b_level && last_b_reg)
        begin
            press_next = 11'd0;
        end
        else if (!item.button_b_level && !last_b_reg)
        begin
            in_window_b = (press_next > cfg.hold_ms) && ({1'b0, press_next} < window_end);
            if (in_window_b)
            begin
                adjust_next = 1'b0;
            end
        end
        else if (item.button_b_level && !last_b_reg)
        begin
            if (adjust_next)
            begin
                if ({1'b0, level_next} < step_plus_one)
                begin
                    level_next = cfg.level_step;
                end
                else
                begin
                    level_next = level_next - cfg.level_step;
                end
                applied_next = level_next;
            end
            else
            begin
                effect_next = effect_next - 8'd1;
            end
        end
        last_b_next = item.button_b_level;

        // Colour selection outside adjust mode; an unknown effect wraps to the first.
        if (!adjust_next)
        begin
            if (effect_next < tblc_pkg::EFFECT_RAINBOW)
            begin
                rgb_next    = tblc_pkg::colour_lookup(effect_next[3:0]);
                is_hsv_next = 1'b0;
            end
            else if (effect_next == tblc_pkg::EFFECT_RAINBOW)
            begin
                is_hsv_next = 1'b1;
                snap_next   = hue_next;
            end
            else
            begin
                effect_next = 8'd0;
            end
        end
    end

    // Result of the item, built from the updated state.
    always_comb
    begin
        result.red              = is_hsv_next ? 8'd0 : rgb_next[23:16];
        result.green            = is_hsv_next ? 8'd0 : rgb_next[15:8];
        result.blue             = is_hsv_next ? 8'd0 : rgb_next[7:0];
        result.hsv_mode         = is_hsv_next;
        result.hue_out          = is_hsv_next ? snap_next : 16'd0;
        result.shown_brightness = applied_next;
        result.level_out        = level_next;
        result.effect_out       = effect_next;
        result.adjust_mode      = adjust_next;
        result.save_strobe      = strobe;
    end

    // State registers; presets must come while no item is in flight; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg    <= 1'b1;
            last_b_reg    <= 1'b1;
            press_reg     <= 11'd0;
            adjust_reg    <= 1'b0;
            effect_reg    <= 8'd0;
            level_reg     <= 8'd255;
            applied_reg   <= 8'd255;
            phase_reg     <= 1'b0;
            blink_cnt_reg <= 8'd0;
            save_cnt_reg  <= 13'd0;
            hue_reg       <= 16'd0;
            rgb_reg       <= 24'd0;
            is_hsv_reg    <= 1'b0;
            snap_reg      <= 16'd0;
        end
        else if (fire)
        begin
            last_a_reg    <= last_a_next;
            last_b_reg    <= last_b_next;
            press_reg     <= press_next;
            adjust_reg    <= adjust_next;
            effect_reg    <= effect_next;
            level_reg     <= level_next;
            applied_reg   <= applied_next;
            phase_reg     <= phase_next;
            blink_cnt_reg <= blink_cnt_next;
            save_cnt_reg  <= save_cnt_next;
            hue_reg       <= hue_next;
            rgb_reg       <= rgb_next;
            is_hsv_reg    <= is_hsv_next;
            snap_reg      <= snap_next;
        end
        else
        begin
            if (preset.load_effect)
            begin
                effect_reg <= preset.value;
            end
            if (preset.load_level)
            begin
                level_reg   <= preset.value;
                applied_reg <= preset.value;
            end
        end
    end

endmodule

/* sv/two_button_lamp_controller_core.sv */
// ============================================================================
// two_button_lamp_controller_core: two-button lamp controller
// Button, blink, save and colour logic for a lamp, one item per clock unless stalled.
// ============================================================================
//  Channel  Direction  Payload
//  s_*      in         tdata[3:0]: ms_tick, period_event, button_a_level, button_b_level
//  m_*      out        tdata[66:0]: colour, hue, brightness, level, effect, flags
//  cfg_*    in         write enable, 3-bit register index, 16-bit data
//
//  An item is held in the input register and moves on into the result
//  register; one item is taken every cycle unless the result stalls. The
//  state update of one item is a single pass of compares and adds. Reset
//  loads the lamp state with its defaults at once; there is no clearing
//  sweep. A stalled result holds in the result register while the input
//  register still takes one further item.
// ============================================================================
module two_button_lamp_controller_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] ms_tick, [1] period_event, [2] button_a_level, [3] button_b_level
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] red, [15:8] green, [23:16] blue, [24] hsv_mode, [40:25] hue_out,
    // [48:41] shown_brightness, [56:49] level_out, [64:57] effect_out,
    // [65] adjust_mode, [66] save_strobe
    output logic [71:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic              in_valid_reg;
    tblc_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    tblc_pkg::result_t out_reg;
    logic              fire;
    tblc_pkg::cfg_t    cfg;
    tblc_pkg::preset_t preset;
    tblc_pkg::result_t result;

    // An item moves on when the result register is free or being emptied.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.ms_tick        <= s_tdata[0];
            in_item_reg.period_event   <= s_tdata[1];
            in_item_reg.button_a_level <= s_tdata[2];
            in_item_reg.button_b_level <= s_tdata[3];
        end
    end

    tblc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .preset    (preset)
    );

    tblc_step u_step
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_item_reg),
        .cfg    (cfg),
        .preset (preset),
        .result (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_reg.save_strobe,
                       out_reg.adjust_mode,
                       out_reg.effect_out,
                       out_reg.level_out,
                       out_reg.shown_brightness,
                       out_reg.hue_out,
                       out_reg.hsv_mode,
                       out_reg.blue,
                       out_reg.green,
                       out_reg.red};

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for two_button_lamp_controller_core
// Drives button, tick and event items through the stream input, tracks the
// lamp state in a scoreboard class and checks every result item field by
// field, across several register settings and idling patterns.
// ============================================================================
module testbench;

    // Scoreboard: keeps its own lamp state and the queue of results due.
    class lamp_tracker;
        // Register copies.
        logic [10:0] hold_ms;
        logic [8:0]  hold_window;
        logic [7:0]  level_step;
        logic [15:0] hue_step;
        logic [7:0]  blink_period;
        logic [11:0] save_period;

        // Lamp state.
        logic        last_a;
        logic        last_b;
        logic [10:0] press_ms;
        logic        adjust;
        logic [7:0]  effect;
        logic [7:0]  level;
        logic [7:0]  shown;
        logic        blink_phase;
        logic [7:0]  blink_cnt;
        logic [12:0] save_cnt;
        logic [15:0] hue;
        logic [23:0] rgb;
        logic        rainbow;
        logic [15:0] hue_snap;

        bit [23:0] palette [13] = '{
            24'hFFFFFF, 24'hFFF496, 24'hFF0000, 24'hFF7F00, 24'hFFFF00,
            24'h80FF00, 24'h00FF00, 24'h00FF80, 24'h00FFFF, 24'h0080FF,
            24'h0000FF, 24'h8000FF, 24'hFF00FF
        };

        tblc_pkg::result_t pending_results [$];
        int unsigned       errors;
        int unsigned       results_seen;

        function new();
            hold_ms      = 11'd1000;
            hold_window  = 9'd20;
            level_step   = 8'd32;
            hue_step     = 16'd128;
            blink_period = 8'd30;
            save_period  = 12'd480;
            last_a       = 1'b1;
            last_b       = 1'b1;
            press_ms     = '0;
            adjust       = 1'b0;
            effect       = 8'd0;
            level        = 8'd255;
            shown        = 8'd255;
            blink_phase  = 1'b0;
            blink_cnt    = '0;
            save_cnt     = '0;
            hue          = '0;
            rgb          = '0;
            rainbow      = 1'b0;
            hue_snap     = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Register write; the two presets also load the working state.
        function void write_reg(tblc_pkg::reg_index_t idx, logic [15:0] v);
            case (idx)
                tblc_pkg::REG_INITIAL_EFFECT: effect = v[7:0];
                tblc_pkg::REG_INITIAL_LEVEL:
                begin
                    level = v[7:0];
                    shown = v[7:0];
                end
                tblc_pkg::REG_HOLD_MS:        hold_ms = v[10:0];
                tblc_pkg::REG_HOLD_WINDOW_MS: hold_window = v[8:0];
                tblc_pkg::REG_LEVEL_STEP:     level_step = v[7:0];
                tblc_pkg::REG_HUE_STEP:       hue_step = v;
                tblc_pkg::REG_BLINK_PERIOD:   blink_period = v[7:0];
                tblc_pkg::REG_SAVE_PERIOD:    save_period = v[11:0];
                default:                      ;
            endcase
        endfunction

        // One button: a new press clears the shared timer, a held press in
        // the window sets or clears adjust mode, a release steps something.
        function void button(logic now, logic was, bit is_a);
            if (!now && was)
            begin
                press_ms = '0;
            end
            else if (!now && !was)
            begin
                if (int'(press_ms) > int'(hold_ms) &&
                    int'(press_ms) < int'(hold_ms) + int'(hold_window))
                    adjust = is_a;
            end
            else if (now && !was)
            begin
                if (adjust)
                begin
                    if (is_a)
                        level = (int'(level) > 255 - int'(level_step)) ?
                                8'd255 : level + level_step;
                    else
                        level = (int'(level) < int'(level_step) + 1) ?
                                level_step : level - level_step;
                    shown = level;
                end
                else
                begin
                    effect = is_a ? effect + 8'd1 : effect - 8'd1;
                end
            end
        endfunction

        // Advance the lamp state by one accepted item and queue its result.
        function void note_item(logic [3:0] it);
            logic              tick;
            logic              ev;
            bit                strobe;
            tblc_pkg::result_t r;
            tick   = it[0];
            ev     = it[1];
            strobe = 1'b0;

            if (tick && press_ms != tblc_pkg::PRESS_MAX)
                press_ms = press_ms + 11'd1;

            // Periodic event: hue, blink divider and save divider.
            if (ev)
            begin
                hue = hue + hue_step;
                if (blink_cnt > blink_period)
                begin
                    if (adjust && !blink_phase)
                    begin
                        shown = 8'd1;
                        blink_phase = 1'b1;
                    end
                    else
                    begin
                        shown = level;
                        blink_phase = 1'b0;
                    end
                    blink_cnt = '0;
                end
                else
                begin
                    blink_cnt = blink_cnt + 8'd1;
                end
                if (save_cnt > {1'b0, save_period})
                begin
                    strobe = 1'b1;
                    save_cnt = '0;
                end
                else
                begin
                    save_cnt = save_cnt + 13'd1;
                end
            end

            button(it[2], last_a, 1'b1);
            last_a = it[2];
            button(it[3], last_b, 1'b0);
            last_b = it[3];

            // Colour selection only outside adjust mode.
            if (!adjust)
            begin
                if (effect < tblc_pkg::EFFECT_RAINBOW)
                begin
                    rgb = palette[effect];
                    rainbow = 1'b0;
                end
                else if (effect == tblc_pkg::EFFECT_RAINBOW)
                begin
                    rainbow = 1'b1;
                    hue_snap = hue;
                end
                else
                begin
                    effect = 8'd0;
                end
            end

            r = '0;
            if (rainbow)
            begin
                r.hue_out = hue_snap;
            end
            else
            begin
                r.red   = rgb[23:16];
                r.green = rgb[15:8];
                r.blue  = rgb[7:0];
            end
            r.hsv_mode         = rainbow;
            r.shown_brightness = shown;
            r.level_out        = level;
            r.effect_out       = effect;
            r.adjust_mode      = adjust;
            r.save_strobe      = strobe;
            pending_results.push_back(r);
        endfunction

        function bit differs(string name, int unsigned want, int unsigned got);
            if (want != got && errors < 10)
                $display("result %0d: %s expected %0d, got %0d",
                         results_seen, name, want, got);
            return want != got;
        endfunction

        // Compare one result item with the oldest one due.
        function void check_result(logic [71:0] d);
            tblc_pkg::result_t e;
            bit                bad;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                if (errors < 10)
                    $display("result %0d: no result was due, got %h", results_seen, d);
                errors++;
                return;
            end
            e   = pending_results.pop_front();
            bad = 1'b0;
            bad |= differs("red", e.red, d[7:0]);
            bad |= differs("green", e.green, d[15:8]);
            bad |= differs("blue", e.blue, d[23:16]);
            bad |= differs("hsv_mode", e.hsv_mode, d[24]);
            bad |= differs("hue_out", e.hue_out, d[40:25]);
            bad |= differs("shown_brightness", e.shown_brightness, d[48:41]);
            bad |= differs("level_out", e.level_out, d[56:49]);
            bad |= differs("effect_out", e.effect_out, d[64:57]);
            bad |= differs("adjust_mode", e.adjust_mode, d[65]);
            bad |= differs("save_strobe", e.save_strobe, d[66]);
            if (bad)
                errors++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    lamp_tracker tracker = new();

    int          tx_idle_pct = 24;
    int          rx_idle_pct = 58;
    bit          stall_req = 1'b0;
    int          stall_left = 0;
    int unsigned items_sent = 0;
    logic [15:0] setting [8];

    two_button_lamp_controller_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random back-pressure, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (stall_req)
        begin
            stall_left = 300;
            stall_req  = 1'b0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor: check results first, then note the item accepted at this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
            if (s_tvalid && s_tready)
                tracker.note_item(s_tdata[3:0]);
        end
    end

    function automatic logic [3:0] pack_item(bit tick, bit ev, bit a, bit b);
        return {b, a, ev, tick};
    endfunction

    function automatic bit rand_ev();
        return $urandom_range(0, 3) == 0;
    endfunction

    function automatic bit rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offer one item, with random gaps before it, and wait for acceptance.
    task automatic send(input logic [3:0] it);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, it};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stop offering and wait until every result has come back; the first
    // edge lets the monitor note the last accepted item.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write the current setting; the presets only when asked.
    task automatic program_regs(input bit presets);
        for (int i = 0; i < 8; i++)
        begin
            if (i >= 2 || presets)
            begin
                cfg_we    <= 1'b1;
                cfg_index <= 3'(i);
                cfg_wdata <= setting[i];
                tracker.write_reg(tblc_pkg::reg_index_t'(i), setting[i]);
                @(posedge clk);
            end
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random gestures: taps and holds of either button, noise and idle runs.
    task automatic random_phase(input int unsigned n);
        int unsigned start;
        int          kind;
        int          k;
        int          lim;
        bit          use_a;
        bit          long_press;
        start = items_sent;
        while (items_sent - start < n)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                use_a      = (kind < 4);
                long_press = kind[1];
                lim = int'(tracker.hold_ms) + int'(tracker.hold_window) + 2;
                if (lim > 40)
                    lim = 40;
                k = long_press ? $urandom_range(1, lim) : $urandom_range(0, 3);
                send(pack_item(rand_bit(), rand_ev(), !use_a, use_a));
                repeat (k)
                    send(pack_item(long_press ? ($urandom_range(0, 6) != 0) :
                                   rand_bit(), rand_ev(), !use_a, use_a));
                send(pack_item(rand_bit(), rand_ev(), 1'b1, 1'b1));
            end
            else if (kind == 8)
            begin
                repeat ($urandom_range(1, 6))
                    send(4'($urandom_range(0, 15)));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send(pack_item(rand_bit(), rand_ev(), 1'b1, 1'b1));
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        logic [3:0] seq_reset [4];
        logic [3:0] seq_hold [21];
        seq_reset = '{4'b1100, 4'b1111, 4'b0100, 4'b1110};
        seq_hold  = '{4'b1110, 4'b1110, 4'b1001, 4'b1001, 4'b1001, 4'b1011, 4'b1100,
                      4'b0101, 4'b1100, 4'b0101, 4'b1100, 4'b1110, 4'b1110, 4'b0101,
                      4'b0101, 4'b0101, 4'b1100, 4'b1001, 4'b1100, 4'b1001, 4'b1100};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, then a B tap that wraps the effect.
        foreach (seq_reset[i])
            send(seq_reset[i]);
        settle();

        // Directed: short hold window, level step of 128, largest hue step, fastest
        // dividers; holds, level clamps, blink and stepping into the rainbow.
        setting = '{16'd12, 16'd250, 16'd1, 16'd3, 16'd128, 16'hFFFF, 16'd0, 16'd0};
        program_regs(1'b1);
        foreach (seq_hold[i])
            send(seq_hold[i]);
        settle();

        // Random phases under changing settings and idling patterns.
        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph < 3)
            begin
                tx_idle_pct = 24;
                rx_idle_pct = 58;
            end
            else if (ph < 6)
            begin
                tx_idle_pct = 58;
                rx_idle_pct = 24;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (ph)
                0: setting = '{16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0};
                4: setting = '{16'd255, 16'd255, 16'd1500, 16'd500, 16'd128, 16'hFFFF,
                               16'd255, 16'd4095};
                8: setting = '{8{16'hFFFF}};
                default:
                begin
                    setting[0] = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255)) :
                                 16'($urandom_range(0, 15));
                    setting[1] = 16'($urandom_range(0, 255));
                    setting[2] = 16'($urandom_range(1, 12));
                    setting[3] = 16'($urandom_range(1, 8));
                    setting[4] = 16'($urandom_range(1, 128));
                    setting[5] = 16'($urandom_range(0, 65535));
                    setting[6] = ($urandom_range(0, 9) == 0) ? 16'd255 :
                                 16'($urandom_range(0, 6));
                    setting[7] = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 4095)) :
                                 16'($urandom_range(0, 20));
                end
            endcase
            program_regs((ph % 4 == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
            // Long receiver hold-off while the sender keeps offering.
            if (ph == 6)
                stall_req = 1'b1;
            random_phase(140);
            settle();
        end

        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
